FILE: rtl/alist_pkg.sv
`default_nettype none

package alist_pkg;

  typedef enum logic [3:0] {
    OP_GET       = 4'd0,
    OP_SET       = 4'd1,
    OP_INS_FRONT = 4'd2,
    OP_INS_BACK  = 4'd3,
    OP_INS_AT    = 4'd4,
    OP_REM_BACK  = 4'd5,
    OP_REM_FRONT = 4'd6,
    OP_REM_AT    = 4'd7,
    OP_SEARCH    = 4'd8,
    OP_CLEAR     = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int ENTRY_W = KEY_W + DATA_W;
  localparam int CNT_OUT_W = 7;

  typedef struct packed {
    logic [1:0]              status;
    logic                    found;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       data;
    logic [CNT_OUT_W-1:0]    count;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/array_list_engine_unit.sv
`default_nettype none

// Dense ordered list of up to DEPTH items (signed key plus data word) held in a
// synchronous memory with one read port and one write port. Every request gives
// exactly one result. Get reads one entry; set, clear and error cases need no
// walk. Insert and remove walk the entries from the position to the back one
// per cycle; insert front and remove front walk the whole list, remove back a
// single entry, and insert back moves no entry. Search walks from the front
// until the first match, over at most count entries. The walk is bound by the
// single read port. A new request is taken once the previous result has moved
// into the output register, even while that result still waits there.
module array_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         op,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_key,
  input  logic [31:0]        item_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] out_key,
  output logic [31:0]        out_data,
  output logic [6:0]         count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int EW = alist_pkg::ENTRY_W;
  localparam int KW = alist_pkg::KEY_W;
  localparam int DW = alist_pkg::DATA_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_WR   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    M_CAP  = 2'd0,
    M_UP   = 2'd1,
    M_DN   = 2'd2,
    M_SRCH = 2'd3
  } mode_t;

  state_t                state;
  mode_t                 mode;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         ptr;
  logic [AW-1:0]         paddr;
  logic [CW-1:0]         rem;
  logic                  pend;
  logic                  first;
  logic [AW-1:0]         widx;
  logic signed [KW-1:0]  ikey;
  logic [DW-1:0]         idata;
  logic [1:0]            res_status;
  logic                  res_found;
  logic signed [KW-1:0]  res_key;
  logic [DW-1:0]         res_data;

  logic [EW-1:0]         mem [DEPTH];
  logic [EW-1:0]         rdata;

  logic [PW-1:0]         cnt_w;
  logic [PW-1:0]         pos_w;
  logic                  pos_ok;
  logic                  is_full;
  logic                  is_empty;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         ins_i;
  logic [AW-1:0]         rm_i;

  logic [1:0]            d_status;
  logic signed [KW-1:0]  d_key;
  logic                  d_walk;
  mode_t                 d_mode;
  logic [AW-1:0]         d_ptr;
  logic [CW-1:0]         d_rem;
  logic [AW-1:0]         d_widx;
  logic [CW-1:0]         d_cnt;
  logic                  d_set;

  logic                  accept;
  logic                  hit;
  logic                  rd_en;
  logic                  we;
  logic [AW-1:0]         wa;
  logic [EW-1:0]         wd;

  logic                  s_ready;
  alist_pkg::result_t    s_res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign cnt_w    = PW'(cnt);
  assign pos_w    = PW'(position);
  assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
  assign is_full  = (cnt == CW'(DEPTH));
  assign is_empty = (cnt == '0);
  assign idx      = AW'(pos_w - PW'(1));

  always_comb begin
    unique case (alist_pkg::op_t'(op)) inside
      alist_pkg::OP_INS_FRONT: ins_i = '0;
      alist_pkg::OP_INS_BACK:  ins_i = AW'(cnt);
      default:                 ins_i = idx;
    endcase
    unique case (alist_pkg::op_t'(op)) inside
      alist_pkg::OP_REM_BACK:  rm_i = AW'(cnt - CW'(1));
      alist_pkg::OP_REM_FRONT: rm_i = '0;
      default:                 rm_i = idx;
    endcase
  end

  always_comb begin
    d_status = alist_pkg::ST_OK;
    d_key    = '0;
    d_walk   = 1'b0;
    d_mode   = M_CAP;
    d_ptr    = idx;
    d_rem    = '0;
    d_widx   = idx;
    d_cnt    = cnt;
    d_set    = 1'b0;
    unique case (alist_pkg::op_t'(op)) inside
      alist_pkg::OP_GET: begin
        if (!pos_ok) begin
          d_status = alist_pkg::ST_BADPOS;
        end else begin
          d_walk = 1'b1;
          d_rem  = CW'(1);
        end
      end
      alist_pkg::OP_SET: begin
        if (!pos_ok) begin
          d_status = alist_pkg::ST_BADPOS;
        end else begin
          d_set = 1'b1;
        end
      end
      alist_pkg::OP_INS_FRONT, alist_pkg::OP_INS_BACK, alist_pkg::OP_INS_AT: begin
        if (is_full) begin
          d_status = alist_pkg::ST_FULL;
        end else if ((alist_pkg::op_t'(op) == alist_pkg::OP_INS_AT) && !pos_ok) begin
          d_status = alist_pkg::ST_BADPOS;
        end else begin
          d_walk = 1'b1;
          d_mode = M_UP;
          d_ptr  = AW'(cnt - CW'(1));
          d_rem  = cnt - CW'(ins_i);
          d_widx = ins_i;
          d_cnt  = cnt + CW'(1);
        end
      end
      alist_pkg::OP_REM_BACK, alist_pkg::OP_REM_FRONT, alist_pkg::OP_REM_AT: begin
        if ((alist_pkg::op_t'(op) == alist_pkg::OP_REM_AT) && !pos_ok) begin
          d_status = alist_pkg::ST_BADPOS;
        end else if (is_empty) begin
          d_status = alist_pkg::ST_EMPTY;
        end else begin
          d_walk = 1'b1;
          d_mode = M_DN;
          d_ptr  = rm_i;
          d_rem  = cnt - CW'(rm_i);
          d_cnt  = cnt - CW'(1);
        end
      end
      alist_pkg::OP_SEARCH: begin
        d_key = '1;
        if (is_empty) begin
          d_status = alist_pkg::ST_EMPTY;
        end else begin
          d_walk = 1'b1;
          d_mode = M_SRCH;
          d_ptr  = '0;
          d_rem  = cnt;
        end
      end
      alist_pkg::OP_CLEAR: begin
        d_cnt = '0;
      end
      default: begin
      end
    endcase
  end

  assign hit   = (state == S_WALK) && pend && (mode == M_SRCH) &&
                 (rdata[EW-1:DW] == ikey);
  assign rd_en = (state == S_WALK) && (rem != '0) && !hit;

  always_comb begin
    we = 1'b0;
    wa = widx;
    wd = {ikey, idata};
    unique case (state)
      S_IDLE: begin
        if (accept && d_set) begin
          we = 1'b1;
          wa = idx;
          wd = {item_key, item_data};
        end
      end
      S_WALK: begin
        if (pend && (mode == M_UP)) begin
          we = 1'b1;
          wa = paddr + AW'(1);
          wd = rdata;
        end else if (pend && (mode == M_DN) && !first) begin
          we = 1'b1;
          wa = paddr - AW'(1);
          wd = rdata;
        end
      end
      S_WR: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata <= mem[ptr];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (accept) begin
            cnt   <= d_cnt;
            state <= d_walk ? S_WALK : S_DONE;
          end
        end
        S_WALK: begin
          pend <= rd_en;
          if (hit) begin
            state <= S_DONE;
          end else if (rem == '0) begin
            state <= (mode == M_UP) ? S_WR : S_DONE;
          end
        end
        S_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (s_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // walk pointers and request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode       <= d_mode;
      ptr        <= d_ptr;
      rem        <= d_rem;
      widx       <= d_widx;
      first      <= 1'b1;
      ikey       <= item_key;
      idata      <= item_data;
      res_status <= d_status;
      res_found  <= 1'b0;
      res_key    <= d_key;
      res_data   <= '0;
    end else if (state == S_WALK) begin
      if (pend) begin
        first <= 1'b0;
        if ((mode == M_CAP) || ((mode == M_DN) && first) || hit) begin
          res_key  <= rdata[EW-1:DW];
          res_data <= rdata[DW-1:0];
        end
        if (hit) begin
          res_found <= 1'b1;
        end
      end
      if (rd_en) begin
        ptr   <= (mode == M_UP) ? ptr - AW'(1) : ptr + AW'(1);
        rem   <= rem - CW'(1);
        paddr <= ptr;
      end
    end
  end

  always_comb begin
    s_res.status = res_status;
    s_res.found  = res_found;
    s_res.key    = res_key;
    s_res.data   = res_data;
    s_res.count  = cnt_w[6:0];
  end

  alist_ostage u_ostage (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (state == S_DONE),
    .s_ready   (s_ready),
    .s_res     (s_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .out_key   (out_key),
    .out_data  (out_data),
    .count     (count)
  );

endmodule

`default_nettype wire

FILE: rtl/alist_ostage.sv
`default_nettype none

module alist_ostage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  alist_pkg::result_t    s_res,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  found,
  output logic signed [31:0]    out_key,
  output logic [31:0]           out_data,
  output logic [6:0]            count
);

  alist_pkg::result_t res;

  assign s_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_ready) begin
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      res <= s_res;
    end
  end

  assign status   = res.status;
  assign found    = res.found;
  assign out_key  = res.key;
  assign out_data = res.data;
  assign count    = res.count;

endmodule

`default_nettype wire

FILE: rtl/alist_chk.sv
`default_nettype none

module alist_chk #(
  parameter int DEPTH = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         status,
  input logic               found,
  input logic signed [31:0] out_key,
  input logic [31:0]        out_data,
  input logic [6:0]         count
);

  localparam logic [6:0] DEPTH_LO = 7'(DEPTH);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found) &&
      $stable(out_key) && $stable(out_data) && $stable(count))
    else $error("stalled result changed");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == alist_pkg::ST_OK)
    else $error("search hit with error status");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == alist_pkg::ST_EMPTY |-> count == 7'd0 && !found)
    else $error("empty status with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == alist_pkg::ST_FULL |-> count == DEPTH_LO)
    else $error("full status below depth");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 127) || (count <= DEPTH_LO))
    else $error("count above depth");

endmodule

bind array_list_engine_unit alist_chk #(.DEPTH(DEPTH)) u_alist_chk (.*);

`default_nettype wire
